// ===== hw/rtl/tdts_pkg.sv =====
// Shared constants, types and width helpers for the tick-driven task scheduler.
`default_nettype none

package tdts_pkg;

  localparam int TASK_COUNT   = 16;
  localparam int COUNTER_BITS = 16;
  localparam int IDX_BITS     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int FIELD_BITS   = 16;
  localparam int SUM_BITS     = ((COUNTER_BITS > FIELD_BITS) ? COUNTER_BITS : FIELD_BITS) + 1;

  localparam logic [SUM_BITS-1:0] CNT_MAX = SUM_BITS'((65'd1 << COUNTER_BITS) - 65'd1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic MODE_LARGEST  = 1'b0;
  localparam logic MODE_SMALLEST = 1'b1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [IDX_BITS-1:0]     idx_t;

  typedef struct packed {
    logic found;
    cnt_t cnt;
    idx_t idx;
  } scan_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] prio;
    cnt_t                  cnt;
    logic                  runnable;
    logic                  present;
  } entry_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic refill;
    logic mode;
  } cell_ctl_t;

  function automatic cnt_t field_to_cnt(input logic [FIELD_BITS-1:0] v);
    logic [SUM_BITS-1:0] w;
    w = SUM_BITS'(v);
    return w[COUNTER_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] cnt_to_field(input cnt_t c);
    logic [SUM_BITS-1:0] w;
    w = SUM_BITS'(c);
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic logic [3:0] idx_to_field(input idx_t i);
    logic [31:0] w;
    w = 32'(i);
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdts_cell.sv =====
// One task table entry with its counter update and one registered stage of the selection scan.
`default_nettype none

module tdts_cell (
  input  wire                logic     clk,
  input  wire                logic     rst_n,
  input  wire tdts_pkg::idx_t          my_idx,
  input  wire tdts_pkg::cell_ctl_t     ctl,
  input  wire tdts_pkg::entry_t        load_data,
  input  wire tdts_pkg::scan_t         scan_in,
  output tdts_pkg::scan_t              scan_out,
  output tdts_pkg::cnt_t               cnt_out
);

  tdts_pkg::cnt_t                  cnt_r, cnt_nxt;
  logic [tdts_pkg::FIELD_BITS-1:0] prio_r;
  logic                            runnable_r;
  logic                            present_r;
  tdts_pkg::scan_t                 scan_r, scan_nxt;

  logic [tdts_pkg::SUM_BITS-1:0] prio_sat;
  logic [tdts_pkg::SUM_BITS-1:0] half_w;
  logic [tdts_pkg::SUM_BITS-1:0] sum_w;
  logic                          eligible;
  logic                          better;

  always_comb begin
    prio_sat = tdts_pkg::SUM_BITS'(prio_r);
    if (prio_sat > tdts_pkg::CNT_MAX) begin
      prio_sat = tdts_pkg::CNT_MAX;
    end
    half_w = tdts_pkg::SUM_BITS'(cnt_r) >> 1;
    sum_w  = half_w + prio_sat;
    if (sum_w > tdts_pkg::CNT_MAX) begin
      sum_w = tdts_pkg::CNT_MAX;
    end

    cnt_nxt = cnt_r;
    if (ctl.load) begin
      cnt_nxt = load_data.cnt;
    end else if (ctl.dec) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - tdts_pkg::COUNTER_BITS'(1);
      end
    end else if (ctl.refill && present_r) begin
      if (ctl.mode == tdts_pkg::MODE_LARGEST) begin
        cnt_nxt = sum_w[tdts_pkg::COUNTER_BITS-1:0];
      end else begin
        cnt_nxt = prio_sat[tdts_pkg::COUNTER_BITS-1:0];
      end
    end
  end

  always_comb begin
    eligible = present_r && runnable_r && (cnt_r != '0);
    if (!scan_in.found) begin
      better = 1'b1;
    end else if (ctl.mode == tdts_pkg::MODE_LARGEST) begin
      better = cnt_r > scan_in.cnt;
    end else begin
      better = cnt_r < scan_in.cnt;
    end
    scan_nxt = scan_in;
    if (eligible && better) begin
      scan_nxt.found = 1'b1;
      scan_nxt.cnt   = cnt_r;
      scan_nxt.idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      prio_r     <= '0;
      runnable_r <= 1'b0;
      present_r  <= 1'b0;
      scan_r     <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      scan_r <= scan_nxt;
      if (ctl.load) begin
        prio_r     <= load_data.prio;
        runnable_r <= load_data.runnable;
        present_r  <= load_data.present;
      end
    end
  end

  assign scan_out = scan_r;
  assign cnt_out  = cnt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tick_driven_task_scheduler.sv =====
// Top level of the tick-driven task scheduler: request handshake, sequencer and the row of cells.
`default_nettype none

// A load request, and a tick that leaves the running task in place, goes from acceptance to the
// ST_DONE state and places its result in the output register from there once that register is
// free; no new request is taken before that result has been placed. A tick that reschedules
// lets the selection scan ripple through the row of task cells, one registered stage per task
// entry other than the idle entry 0, and its result is placed once the scan is done, or once
// the table has been refilled and scanned again when no entry was found. One request is in
// progress at a time; a finished result waits in the output register and the next request is
// taken once it has been placed there. The user must write the sched_mode register with
// cfg_wr_en only while no request is in progress; the block itself does not enforce this.
module tick_driven_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [3:0]  in_task_index,
  input  wire logic [15:0] in_entry_priority,
  input  wire logic [15:0] in_entry_counter,
  input  wire logic        in_entry_runnable,
  input  wire logic        in_entry_present,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_current_task,
  output logic             out_switched,
  output logic             out_refilled,
  output logic [15:0]      out_current_slices
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  tdts_pkg::idx_t      scan_cnt_r, scan_cnt_nxt;
  tdts_pkg::idx_t      running_r, running_nxt;
  tdts_pkg::idx_t      before_r, before_nxt;
  logic                refilled_r, refilled_nxt;
  logic                mode_r;
  tdts_pkg::cnt_t      idle_cnt_r;
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          out_task_r, out_task_nxt;
  logic                out_switched_r, out_switched_nxt;
  logic                out_refilled_r, out_refilled_nxt;
  logic [15:0]         out_slices_r, out_slices_nxt;

  logic                accept;
  logic                load_hit;
  logic                load_ok;
  logic                dec_en;
  logic                scan_done;
  logic                refill_en;
  tdts_pkg::cnt_t      cur_cnt;
  tdts_pkg::entry_t    load_data;
  tdts_pkg::scan_t     chain [1:tdts_pkg::TASK_COUNT];
  tdts_pkg::cnt_t      cnt_vec [tdts_pkg::TASK_COUNT];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_ok   = (32'(in_task_index) < tdts_pkg::TASK_COUNT);
  assign load_hit  = accept && (in_op == tdts_pkg::OP_LOAD) && load_ok;
  assign dec_en    = accept && (in_op == tdts_pkg::OP_TICK) && (running_r != '0);
  assign scan_done = (state_r == ST_SCAN) &&
                     (scan_cnt_r == tdts_pkg::IDX_BITS'(tdts_pkg::TASK_COUNT - 1));
  assign refill_en = scan_done && !chain[1].found && !refilled_r;
  assign cur_cnt   = cnt_vec[running_r];

  assign load_data.prio     = in_entry_priority;
  assign load_data.cnt      = tdts_pkg::field_to_cnt(in_entry_counter);
  assign load_data.runnable = in_entry_runnable;
  assign load_data.present  = in_entry_present;

  assign chain[tdts_pkg::TASK_COUNT] = '0;
  assign cnt_vec[0] = idle_cnt_r;

  for (genvar gi = 1; gi < tdts_pkg::TASK_COUNT; gi++) begin : g_cell
    tdts_pkg::cell_ctl_t ctl;

    assign ctl.load   = load_hit && (32'(in_task_index) == gi);
    assign ctl.dec    = dec_en && (32'(running_r) == gi);
    assign ctl.refill = refill_en;
    assign ctl.mode   = mode_r;

    tdts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .my_idx    (tdts_pkg::IDX_BITS'(gi)),
      .ctl       (ctl),
      .load_data (load_data),
      .scan_in   (chain[gi+1]),
      .scan_out  (chain[gi]),
      .cnt_out   (cnt_vec[gi])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    scan_cnt_nxt     = scan_cnt_r;
    running_nxt      = running_r;
    before_nxt       = before_r;
    refilled_nxt     = refilled_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_task_nxt     = out_task_r;
    out_switched_nxt = out_switched_r;
    out_refilled_nxt = out_refilled_r;
    out_slices_nxt   = out_slices_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          before_nxt   = running_r;
          refilled_nxt = 1'b0;
          scan_cnt_nxt = '0;
          if (in_op == tdts_pkg::OP_LOAD) begin
            state_nxt = ST_DONE;
          end else if (running_r == '0 || cur_cnt <= tdts_pkg::COUNTER_BITS'(1)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + tdts_pkg::IDX_BITS'(1);
        if (scan_done) begin
          if (chain[1].found) begin
            running_nxt = chain[1].idx;
            state_nxt   = ST_DONE;
          end else if (!refilled_r) begin
            refilled_nxt = 1'b1;
            scan_cnt_nxt = '0;
          end else begin
            running_nxt = '0;
            state_nxt   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_task_nxt     = tdts_pkg::idx_to_field(running_r);
          out_switched_nxt = (running_r != before_r);
          out_refilled_nxt = refilled_r;
          out_slices_nxt   = tdts_pkg::cnt_to_field(cur_cnt);
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      scan_cnt_r     <= '0;
      running_r      <= '0;
      before_r       <= '0;
      refilled_r     <= 1'b0;
      mode_r         <= tdts_pkg::MODE_LARGEST;
      idle_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
      out_task_r     <= '0;
      out_switched_r <= 1'b0;
      out_refilled_r <= 1'b0;
      out_slices_r   <= '0;
    end else begin
      state_r        <= state_nxt;
      scan_cnt_r     <= scan_cnt_nxt;
      running_r      <= running_nxt;
      before_r       <= before_nxt;
      refilled_r     <= refilled_nxt;
      out_valid_r    <= out_valid_nxt;
      out_task_r     <= out_task_nxt;
      out_switched_r <= out_switched_nxt;
      out_refilled_r <= out_refilled_nxt;
      out_slices_r   <= out_slices_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (load_hit && in_task_index == 4'd0) begin
        idle_cnt_r <= load_data.cnt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_task   = out_task_r;
  assign out_switched       = out_switched_r;
  assign out_refilled       = out_refilled_r;
  assign out_current_slices = out_slices_r;

endmodule

`default_nettype wire
